FILE: hdl/bpt_pkg.sv
package bpt_pkg;

  // table size
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W  = 16;

  // request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_STEP   = 2'd3;

  // result status
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // table operations
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  // Z80 opcode classes: CALL nn, CALL cc,nn (11ccc100), RST p (11ppp111)
  localparam logic [7:0] OPC_CALL       = 8'hcd;
  localparam logic [7:0] OPC_GROUP_MASK = 8'hc7;
  localparam logic [7:0] OPC_CCALL_BITS = 8'hc4;
  localparam logic [7:0] OPC_RST_BITS   = 8'hc7;

  localparam logic [ADDR_W-1:0] CALL_LEN = 16'd3;
  localparam logic [ADDR_W-1:0] RST_LEN  = 16'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] pc;
    logic [7:0]        opcode;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic              is_subroutine;
    logic [ADDR_W-1:0] placed_addr;
    logic [1:0]        status;
  } out_t;

  // decoded request, decode -> store and result logic
  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] key;
    logic              subroutine;
    logic [ADDR_W-1:0] placed;
  } dec_t;

  // table response
  typedef struct packed {
    logic present;
    logic full;
  } look_t;

endpackage

FILE: hdl/bpt_decode.sv
module bpt_decode (
  input  bpt_pkg::in_t  item,
  output bpt_pkg::dec_t dec
);

  logic is_call;
  logic is_rst;

  assign is_call = (item.opcode == bpt_pkg::OPC_CALL) ||
                   ((item.opcode & bpt_pkg::OPC_GROUP_MASK) == bpt_pkg::OPC_CCALL_BITS);
  assign is_rst  = (item.opcode & bpt_pkg::OPC_GROUP_MASK) == bpt_pkg::OPC_RST_BITS;

  always_comb begin
    dec.subroutine = is_call || is_rst;
    dec.op         = bpt_pkg::OP_NONE;
    dec.key        = item.addr;
    dec.placed     = '0;
    case (item.kind)
      bpt_pkg::KIND_ADD:    dec.op = bpt_pkg::OP_INSERT;
      bpt_pkg::KIND_REMOVE: dec.op = bpt_pkg::OP_REMOVE;
      bpt_pkg::KIND_QUERY:  dec.op = bpt_pkg::OP_LOOKUP;
      bpt_pkg::KIND_STEP: begin
        if (is_call || is_rst) begin
          dec.op     = bpt_pkg::OP_INSERT;
          dec.placed = item.pc + (is_call ? bpt_pkg::CALL_LEN : bpt_pkg::RST_LEN);
          dec.key    = dec.placed;
        end
      end
      default: dec.op = bpt_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: hdl/bpt_store.sv
module bpt_store (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  bpt_pkg::dec_t dec,
  output bpt_pkg::look_t look
);

  logic [bpt_pkg::ADDR_W-1:0]  entry_address [bpt_pkg::ENTRIES];
  logic [bpt_pkg::ENTRIES-1:0] entry_valid;
  logic [bpt_pkg::ENTRIES-1:0] match;
  logic [bpt_pkg::IDX_W-1:0]   free_idx;
  logic                        do_insert;

  // parallel compare over all entries
  always_comb begin
    for (int i = 0; i < bpt_pkg::ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_address[i] == dec.key);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = bpt_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) free_idx = bpt_pkg::IDX_W'(i);
    end
  end

  assign look.present = |match;
  assign look.full    = &entry_valid;
  assign do_insert    = en && (dec.op == bpt_pkg::OP_INSERT) && !look.present && !look.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (en) begin
      if (dec.op == bpt_pkg::OP_REMOVE) begin
        entry_valid <= entry_valid & ~match;
      end else if (do_insert) begin
        entry_valid[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      entry_address[free_idx] <= dec.key;
    end
  end

endmodule

FILE: hdl/breakpoint_table_with_step_over.sv
// Breakpoint address table with step-over insertion.
//
// Request channel (req_valid / req_ready / req): one beat per command, kind
// add, remove, query or step-over. Step-over looks at the opcode at pc and,
// for a call or rst, inserts the return address pc+3 or pc+1 (mod 2^16).
// Response channel (rsp_valid / rsp_ready / rsp): exactly one beat per
// request, in order: hit, is_subroutine, placed_addr and status.
//
// Pipeline: the edge that takes the request beat loads the input register;
// once the response register is free or draining, it is loaded after a single
// pass of decode plus a parallel compare against all ENTRIES slots, and
// rsp_valid rises. One request per cycle is sustained while rsp_ready stays
// high; the table updates on the edge that loads the response, so the next
// request already sees it.
// When the receiver stalls, the response register holds, the input register
// fills, and req_ready drops; no beat is lost or repeated.
// Reset (rst, synchronous) empties the table and both pipeline registers;
// a request may be offered the cycle after reset is released.
module breakpoint_table_with_step_over (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bpt_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bpt_pkg::out_t rsp
);

  // input stage
  logic          s1_valid;
  bpt_pkg::in_t  s1_item;
  logic          advance;

  bpt_pkg::dec_t  dec;
  bpt_pkg::look_t look;
  bpt_pkg::out_t  rsp_next;

  // stage 1 moves on when the response register is free or being drained
  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_item <= req;
    end
  end

  bpt_decode u_decode (
    .item (s1_item),
    .dec  (dec)
  );

  // table commits only when the result moves into the response register
  bpt_store u_store (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .dec  (dec),
    .look (look)
  );

  // result assembly; present wins over full on insert (no-op duplicate)
  always_comb begin
    rsp_next.is_subroutine = dec.subroutine;
    rsp_next.placed_addr   = dec.placed;
    rsp_next.hit           = 1'b0;
    rsp_next.status        = bpt_pkg::ST_DONE;
    case (dec.op)
      bpt_pkg::OP_INSERT: begin
        if (look.present || !look.full) begin
          rsp_next.hit = 1'b1;
        end else begin
          rsp_next.status = bpt_pkg::ST_FULL;
        end
      end
      bpt_pkg::OP_LOOKUP: rsp_next.hit = look.present;
      bpt_pkg::OP_REMOVE: rsp_next.hit = 1'b0;
      bpt_pkg::OP_NONE:   rsp_next.status = bpt_pkg::ST_NONE;
      default:            rsp_next.status = bpt_pkg::ST_NONE;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule
